// ===== sv/bpa_pkg.sv =====
// Shared types, constants and helper functions for the buddy page allocator.
// No dependencies; used by buddy_page_allocator_top and its testbench.
package bpa_pkg;

  localparam int MAX_PAGES  = 4096;
  localparam int NUM_ORDERS = 11;
  localparam int PAGE_W     = 12;
  localparam int LINK_W     = 13;
  localparam int ORD_W      = 4;
  localparam int CNT_W      = 32;
  localparam logic [LINK_W-1:0] NIL = 13'd4096;

  // Operation codes
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_INIT  = 2'd2;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_OUT,
    ST_A_START, ST_A_SPLIT,
    ST_F_CHUNK, ST_F_BUD, ST_F_BCK, ST_F_MERGE, ST_F_NEXT,
    ST_I_CARVE, ST_I_ADV,
    ST_U_RD, ST_U_CK, ST_U_PV, ST_U_NX0, ST_U_NX,
    ST_P_RD, ST_P_CK, ST_P_H
  } st_e;

  // One page entry of the page table
  typedef struct packed {
    logic              mark;
    logic [ORD_W-1:0]  ord;
    logic [LINK_W-1:0] nxt;
    logic [LINK_W-1:0] prv;
  } page_ent_t;

  localparam int ENT_W = $bits(page_ent_t);

  // Largest order whose block is aligned at idx and fits in remain (remain >= 1)
  function automatic logic [ORD_W-1:0] largest_aligned(logic [LINK_W-1:0] idx,
                                                      logic [LINK_W-1:0] remain);
    logic [ORD_W-1:0] o;
    logic             go;
    o  = '0;
    go = 1'b1;
    for (int k = 1; k < NUM_ORDERS; k++) begin
      if (go && ((LINK_W'(1) << k) <= remain) &&
          ((idx & ((LINK_W'(1) << k) - LINK_W'(1))) == '0)) begin
        o = ORD_W'(k);
      end else begin
        go = 1'b0;
      end
    end
    return o;
  endfunction

  // Smallest order whose block holds cnt pages
  function automatic logic [ORD_W-1:0] order_for_count(logic [LINK_W-1:0] cnt);
    logic [ORD_W-1:0] n;
    n = '0;
    for (int k = 0; k < LINK_W; k++) begin
      if ((LINK_W'(1) << k) < cnt) n = ORD_W'(k + 1);
    end
    return n;
  endfunction

endpackage

// ===== sv/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/buddy_page_allocator_top.sv =====
// Buddy page allocator: sequencer over one page-table RAM and the order list heads.
// Depends on bpa_pkg and bpa_ram.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: func, page_count, start_index
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: status, block_index, free_total
// cfg       in   cfg_we_i                     cfg_wdata_i: total_pages
//
// One item at a time; most steps are a read or read-modify-write of the page-table RAM.
// Allocate splits the lowest fitting free block down to the request; free releases the
// range in aligned chunks, merging with free buddies; init clears the table and carves blocks.
// After reset a clearing sweep over all 4096 entries runs before the first item is taken.
// The result is held in an output register until taken; no new item meanwhile.
module buddy_page_allocator_top
  import bpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] func, [14:2] page_count, [26:15] start_index
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] status, [12:1] block_index, [25:13] free_total
  output logic [31:0] m_axis_tdata
);

  st_e               state_q, state_d, u_ret_q, u_ret_d, p_ret_q, p_ret_d;
  logic [PAGE_W-1:0] u_p_q, u_p_d, p_p_q, p_p_d, ph_q, ph_d, blk_q, blk_d;
  logic [PAGE_W-1:0] b_q, b_d, oth_q, oth_d, clr_q, clr_d;
  logic [ORD_W-1:0]  p_ord_q, p_ord_d, need_q, need_d, a_o_q, a_o_d;
  logic [ORD_W-1:0]  lo_q, lo_d, cur_q, cur_d;
  logic [LINK_W-1:0] u_nx_q, u_nx_d, u_pv_q, u_pv_d, idx_q, idx_d, left_q, left_d;
  logic [LINK_W-1:0] tp_q;
  logic [LINK_W-1:0] heads_q [NUM_ORDERS];
  logic [LINK_W-1:0] heads_d [NUM_ORDERS];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              init_q, init_d, status_q, status_d;

  logic              mem_we;
  logic [PAGE_W-1:0] mem_waddr, mem_raddr;
  page_ent_t         mem_wdata, rd;
  logic [ENT_W-1:0]  rdata;

  logic [1:0]        in_func;
  logic [LINK_W-1:0] in_cnt;
  logic [PAGE_W-1:0] in_start;
  logic [LINK_W-1:0] room;
  logic [LINK_W-1:0] n_init;
  logic [PAGE_W-1:0] buddy;
  logic              found;
  logic [ORD_W-1:0]  fo;

  assign in_func  = s_axis_tdata[1:0];
  assign in_cnt   = s_axis_tdata[14:2];
  assign in_start = s_axis_tdata[26:15];
  assign room     = LINK_W'(MAX_PAGES) - {1'b0, in_start};
  assign n_init   = (tp_q > LINK_W'(MAX_PAGES)) ? LINK_W'(MAX_PAGES) : tp_q;
  assign buddy    = b_q ^ (PAGE_W'(1) << cur_q);
  assign rd       = page_ent_t'(rdata);

  bpa_ram #(.DEPTH(MAX_PAGES), .WIDTH(ENT_W)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  // Lowest non-empty order at or above the request
  always_comb begin
    found = 1'b0;
    fo    = '0;
    for (int k = 0; k < NUM_ORDERS; k++) begin
      if (!found && ORD_W'(k) >= need_q && heads_q[k] != NIL) begin
        found = 1'b1;
        fo    = ORD_W'(k);
      end
    end
  end

  // Next state and datapath
  always_comb begin
    state_d  = state_q;
    u_ret_d  = u_ret_q;
    p_ret_d  = p_ret_q;
    u_p_d    = u_p_q;
    p_p_d    = p_p_q;
    ph_d     = ph_q;
    blk_d    = blk_q;
    b_d      = b_q;
    oth_d    = oth_q;
    clr_d    = clr_q;
    p_ord_d  = p_ord_q;
    need_d   = need_q;
    a_o_d    = a_o_q;
    lo_d     = lo_q;
    cur_d    = cur_q;
    u_nx_d   = u_nx_q;
    u_pv_d   = u_pv_q;
    idx_d    = idx_q;
    left_d   = left_q;
    heads_d  = heads_q;
    cnt_d    = cnt_q;
    init_d   = init_q;
    status_d = status_q;
    case (state_q)
      ST_CLR: begin
        clr_d = clr_q + PAGE_W'(1);
        if (clr_q == PAGE_W'(MAX_PAGES - 1)) begin
          state_d = init_q ? ST_I_CARVE : ST_IDLE;
          init_d  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          status_d = 1'b0;
          blk_d    = '0;
          case (in_func)
            FUNC_ALLOC: begin
              need_d = order_for_count(in_cnt);
              if (in_cnt == '0 || order_for_count(in_cnt) >= ORD_W'(NUM_ORDERS)) begin
                status_d = 1'b1;
                state_d  = ST_OUT;
              end else begin
                state_d = ST_A_START;
              end
            end
            FUNC_FREE: begin
              idx_d   = {1'b0, in_start};
              left_d  = (in_cnt > room) ? room : in_cnt;
              state_d = ST_F_CHUNK;
            end
            FUNC_INIT: begin
              for (int k = 0; k < NUM_ORDERS; k++) heads_d[k] = NIL;
              cnt_d   = '0;
              init_d  = 1'b1;
              clr_d   = '0;
              idx_d   = '0;
              left_d  = n_init;
              state_d = ST_CLR;
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_A_START: begin
        if (!found) begin
          status_d = 1'b1;
          state_d  = ST_OUT;
        end else begin
          u_p_d   = heads_q[fo][PAGE_W-1:0];
          blk_d   = heads_q[fo][PAGE_W-1:0];
          a_o_d   = fo;
          u_ret_d = ST_A_SPLIT;
          state_d = ST_U_RD;
        end
      end
      ST_A_SPLIT: begin
        if (a_o_q > need_q) begin
          a_o_d   = a_o_q - ORD_W'(1);
          p_ord_d = a_o_q - ORD_W'(1);
          p_p_d   = blk_q + (PAGE_W'(1) << (a_o_q - ORD_W'(1)));
          p_ret_d = ST_A_SPLIT;
          state_d = ST_P_RD;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_F_CHUNK: begin
        if (left_q != '0 && !idx_q[PAGE_W]) begin
          lo_d    = largest_aligned(idx_q, left_q);
          cur_d   = largest_aligned(idx_q, left_q);
          b_d     = idx_q[PAGE_W-1:0];
          u_p_d   = idx_q[PAGE_W-1:0];
          u_ret_d = ST_F_BUD;
          state_d = ST_U_RD;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_F_BUD: begin
        if (cur_q < ORD_W'(NUM_ORDERS - 1)) begin
          oth_d   = buddy;
          state_d = ST_F_BCK;
        end else begin
          p_p_d   = b_q;
          p_ord_d = cur_q;
          p_ret_d = ST_F_NEXT;
          state_d = ST_P_RD;
        end
      end
      ST_F_BCK: begin
        if (rd.mark && rd.ord == cur_q) begin
          u_p_d   = oth_q;
          u_ret_d = ST_F_MERGE;
          state_d = ST_U_RD;
        end else begin
          p_p_d   = b_q;
          p_ord_d = cur_q;
          p_ret_d = ST_F_NEXT;
          state_d = ST_P_RD;
        end
      end
      ST_F_MERGE: begin
        if (oth_q < b_q) b_d = oth_q;
        cur_d   = cur_q + ORD_W'(1);
        state_d = ST_F_BUD;
      end
      ST_F_NEXT: begin
        idx_d   = idx_q + (LINK_W'(1) << lo_q);
        left_d  = left_q - (LINK_W'(1) << lo_q);
        state_d = ST_F_CHUNK;
      end
      ST_I_CARVE: begin
        if (idx_q < left_q) begin
          lo_d    = largest_aligned(idx_q, left_q - idx_q);
          p_ord_d = largest_aligned(idx_q, left_q - idx_q);
          p_p_d   = idx_q[PAGE_W-1:0];
          p_ret_d = ST_I_ADV;
          state_d = ST_P_RD;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_I_ADV: begin
        idx_d   = idx_q + (LINK_W'(1) << lo_q);
        state_d = ST_I_CARVE;
      end
      // unlink subroutine
      ST_U_RD: state_d = ST_U_CK;
      ST_U_CK: begin
        if (!rd.mark) begin
          state_d = u_ret_q;
        end else begin
          u_nx_d = rd.nxt;
          u_pv_d = rd.prv;
          cnt_d  = cnt_q - (CNT_W'(1) << rd.ord);
          if (rd.prv != NIL) begin
            state_d = ST_U_PV;
          end else begin
            heads_d[rd.ord] = rd.nxt;
            state_d         = ST_U_NX0;
          end
        end
      end
      ST_U_PV:  state_d = ST_U_NX0;
      ST_U_NX0: state_d = (u_nx_q != NIL) ? ST_U_NX : u_ret_q;
      ST_U_NX:  state_d = u_ret_q;
      // push subroutine
      ST_P_RD: state_d = ST_P_CK;
      ST_P_CK: begin
        if (rd.mark) begin
          u_p_d   = p_p_q;
          u_ret_d = ST_P_RD;
          state_d = ST_U_RD;
        end else begin
          heads_d[p_ord_q] = {1'b0, p_p_q};
          cnt_d            = cnt_q + (CNT_W'(1) << p_ord_q);
          ph_d             = heads_q[p_ord_q][PAGE_W-1:0];
          state_d          = (heads_q[p_ord_q] != NIL) ? ST_P_H : p_ret_q;
        end
      end
      ST_P_H: state_d = p_ret_q;
      ST_OUT: begin
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // RAM port and handshake outputs
  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_OUT:   m_axis_tvalid = 1'b1;
      ST_F_BUD: mem_raddr = buddy;
      ST_U_RD:  mem_raddr = u_p_q;
      ST_U_CK: begin
        mem_raddr = rd.prv[PAGE_W-1:0];
        if (rd.mark) begin
          mem_we         = 1'b1;
          mem_waddr      = u_p_q;
          mem_wdata      = rd;
          mem_wdata.mark = 1'b0;
        end
      end
      ST_U_PV: begin
        mem_we        = 1'b1;
        mem_waddr     = u_pv_q[PAGE_W-1:0];
        mem_wdata     = rd;
        mem_wdata.nxt = u_nx_q;
      end
      ST_U_NX0: mem_raddr = u_nx_q[PAGE_W-1:0];
      ST_U_NX: begin
        mem_we        = 1'b1;
        mem_waddr     = u_nx_q[PAGE_W-1:0];
        mem_wdata     = rd;
        mem_wdata.prv = u_pv_q;
      end
      ST_P_RD: mem_raddr = p_p_q;
      ST_P_CK: begin
        mem_raddr = heads_q[p_ord_q][PAGE_W-1:0];
        if (!rd.mark) begin
          mem_we    = 1'b1;
          mem_waddr = p_p_q;
          mem_wdata = '{mark: 1'b1, ord: p_ord_q, nxt: heads_q[p_ord_q], prv: NIL};
        end
      end
      ST_P_H: begin
        mem_we        = 1'b1;
        mem_waddr     = ph_q;
        mem_wdata     = rd;
        mem_wdata.prv = {1'b0, p_p_q};
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {6'd0,
                         (cnt_q > CNT_W'(8191)) ? 13'h1FFF : cnt_q[LINK_W-1:0],
                         blk_q, status_q};

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q   <= '0;
      init_q  <= 1'b0;
      cnt_q   <= '0;
      tp_q    <= '0;
      for (int k = 0; k < NUM_ORDERS; k++) heads_q[k] <= NIL;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      init_q  <= init_d;
      cnt_q   <= cnt_d;
      heads_q <= heads_d;
      if (cfg_we_i) tp_q <= cfg_wdata_i;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    u_ret_q  <= u_ret_d;
    p_ret_q  <= p_ret_d;
    u_p_q    <= u_p_d;
    p_p_q    <= p_p_d;
    ph_q     <= ph_d;
    blk_q    <= blk_d;
    b_q      <= b_d;
    oth_q    <= oth_d;
    p_ord_q  <= p_ord_d;
    need_q   <= need_d;
    a_o_q    <= a_o_d;
    lo_q     <= lo_d;
    cur_q    <= cur_d;
    u_nx_q   <= u_nx_d;
    u_pv_q   <= u_pv_d;
    idx_q    <= idx_d;
    left_q   <= left_d;
    status_q <= status_d;
  end

`ifndef ASSERT_OFF
  a_one_side : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
  a_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
  a_fail_blk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[12:1] == '0)
    else $error("failed allocate with nonzero block");
  a_clr_nowr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLR |-> !s_axis_tready && !m_axis_tvalid)
    else $error("handshake during clearing sweep");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for buddy_page_allocator_top: directed table, then random traffic.
// Holds its own allocator predictor; depends on bpa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module testbench;
  import bpa_pkg::*;

  localparam int CYCLE_LIMIT = 20_000_000;

  typedef struct {
    bit        st;
    bit [11:0] blk;
    bit [12:0] fp;
  } result_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [1:0] func;
    int         cnt;
    int         start;
    bit         typed;
    result_t    res;
  } row_t;

  // Op code that the block treats as a no-op
  localparam logic [1:0] FUNC_NOP = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [12:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  buddy_page_allocator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: page table, list heads, free count, managed pages
  bit          pg_mark[MAX_PAGES];
  int          pg_ord[MAX_PAGES];
  int          pg_next[MAX_PAGES];
  int          pg_prev[MAX_PAGES];
  int          list_head[NUM_ORDERS];
  int unsigned pages_free;
  int          pages_cfg;

  result_t     pending_q[$];
  int          held_base[$];
  int          held_size[$];
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;

  function automatic void detach_block(int p);
    int o, nx, pv;
    if (p >= MAX_PAGES || !pg_mark[p]) return;
    o  = pg_ord[p];
    nx = pg_next[p];
    pv = pg_prev[p];
    if (pv < MAX_PAGES) pg_next[pv] = nx;
    else list_head[o] = nx;
    if (nx < MAX_PAGES) pg_prev[nx] = pv;
    pg_mark[p] = 1'b0;
    pages_free -= 1 << o;
  endfunction

  function automatic void attach_block(int o, int p);
    int h;
    if (p >= MAX_PAGES || o >= NUM_ORDERS) return;
    if (pg_mark[p]) detach_block(p);
    h = list_head[o];
    pg_next[p] = h;
    pg_prev[p] = MAX_PAGES;
    if (h < MAX_PAGES) pg_prev[h] = p;
    list_head[o] = p;
    pg_ord[p] = o;
    pg_mark[p] = 1'b1;
    pages_free += 1 << o;
  endfunction

  function automatic int fit_order(int idx, int remain);
    int o;
    o = 0;
    while (o + 1 < NUM_ORDERS && (1 << (o + 1)) <= remain && (idx & ((1 << (o + 1)) - 1)) == 0)
      o++;
    return o;
  endfunction

  function automatic void wipe_tables();
    foreach (pg_mark[i]) pg_mark[i] = 1'b0;
    foreach (list_head[i]) list_head[i] = MAX_PAGES;
    pages_free = 0;
  endfunction

  // Apply one item to the predictor; returns the result it should give
  function automatic result_t allocator_step(logic [1:0] func, int cnt, int start);
    result_t r;
    int n, idx, o, need, s, left, b, cur, other;
    r = '{1'b0, 12'd0, 13'd0};
    case (func)
      FUNC_INIT: begin
        n = pages_cfg > MAX_PAGES ? MAX_PAGES : pages_cfg;
        idx = 0;
        wipe_tables();
        held_base.delete();
        held_size.delete();
        while (idx < n) begin
          o = fit_order(idx, n - idx);
          attach_block(o, idx);
          idx += 1 << o;
        end
      end
      FUNC_ALLOC: begin
        need = 0;
        s = 1;
        if (cnt == 0) r.st = 1'b1;
        else begin
          while (s < cnt) begin
            s <<= 1;
            need++;
          end
          if (need >= NUM_ORDERS) r.st = 1'b1;
          else begin
            o = need;
            while (o < NUM_ORDERS && list_head[o] >= MAX_PAGES) o++;
            if (o >= NUM_ORDERS) r.st = 1'b1;
            else begin
              idx = list_head[o];
              detach_block(idx);
              while (o > need) begin
                o--;
                attach_block(o, idx + (1 << o));
              end
              r.blk = idx[11:0];
              held_base.push_back(idx);
              held_size.push_back(1 << need);
            end
          end
        end
      end
      FUNC_FREE: begin
        idx = start;
        left = cnt;
        if (left > MAX_PAGES - idx) left = MAX_PAGES - idx;
        while (left > 0 && idx < MAX_PAGES) begin
          o = fit_order(idx, left);
          b = idx;
          cur = o;
          if (pg_mark[b]) detach_block(b);
          while (cur + 1 < NUM_ORDERS) begin
            other = b ^ (1 << cur);
            if (other >= MAX_PAGES || !pg_mark[other] || pg_ord[other] != cur) break;
            detach_block(other);
            if (other < b) b = other;
            cur++;
          end
          attach_block(cur, b);
          idx += 1 << o;
          left -= 1 << o;
        end
      end
      default: ;
    endcase
    r.fp = pages_free > 8191 ? 13'h1FFF : pages_free[12:0];
    return r;
  endfunction

  // Offer one item; once taken, predict it (or queue the typed result)
  task automatic send_item(logic [1:0] func, int cnt, int start, bit typed, result_t res);
    result_t r;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, start[11:0], cnt[12:0], func};
    do @(posedge clk_i); while (!s_axis_tready);
    r = allocator_step(func, cnt, start);
    pending_q.push_back(typed ? res : r);
  endtask

  // Hold off the sender until every result is back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_pages(int value);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[12:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    pages_cfg = value;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (m_axis_tdata[0] !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, m_axis_tdata[0]);
          errors++;
        end
        if (m_axis_tdata[12:1] !== want.blk) begin
          $display("%0t: block_index expected %0d actual %0d", $time, want.blk,
                   m_axis_tdata[12:1]);
          errors++;
        end
        if (m_axis_tdata[25:13] !== want.fp) begin
          $display("%0t: free_total expected %0d actual %0d", $time, want.fp,
                   m_axis_tdata[25:13]);
          errors++;
        end
      end
    end
  end

  // Receiver stalls
  always @(negedge clk_i)
    m_axis_tready <= calm || $urandom_range(99) >= 6;

  // Run guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  row_t plan[$] = '{
    '{ROW_ITEM, FUNC_ALLOC, 1,    0,    1, '{1, 0, 0}},
    '{ROW_ITEM, FUNC_ALLOC, 0,    0,    1, '{1, 0, 0}},
    '{ROW_ITEM, FUNC_NOP,   7,    9,    1, '{0, 0, 0}},
    '{ROW_ITEM, FUNC_FREE,  0,    5,    1, '{0, 0, 0}},
    '{ROW_CFG,  FUNC_INIT,  4096, 0,    0, '{0, 0, 0}},
    '{ROW_ITEM, FUNC_INIT,  0,    0,    1, '{0, 0, 4096}},
    '{ROW_ITEM, FUNC_ALLOC, 1025, 0,    1, '{1, 0, 4096}},
    '{ROW_ITEM, FUNC_ALLOC, 8191, 0,    1, '{1, 0, 4096}},
    '{ROW_ITEM, FUNC_ALLOC, 1,    0,    0, '{0, 0, 0}},
    '{ROW_ITEM, FUNC_ALLOC, 1024, 0,    0, '{0, 0, 0}},
    '{ROW_ITEM, FUNC_ALLOC, 3,    0,    0, '{0, 0, 0}},
    '{ROW_ITEM, FUNC_FREE,  1,    3072, 0, '{0, 0, 0}},
    '{ROW_ITEM, FUNC_FREE,  8191, 4095, 0, '{0, 0, 0}},
    '{ROW_ITEM, FUNC_FREE,  4096, 0,    0, '{0, 0, 0}},
    '{ROW_ITEM, FUNC_FREE,  4096, 1,    0, '{0, 0, 0}},
    '{ROW_CFG,  FUNC_INIT,  8191, 0,    0, '{0, 0, 0}},
    '{ROW_ITEM, FUNC_INIT,  0,    0,    1, '{0, 0, 4096}},
    '{ROW_CFG,  FUNC_INIT,  0,    0,    0, '{0, 0, 0}},
    '{ROW_ITEM, FUNC_INIT,  0,    0,    1, '{0, 0, 0}},
    '{ROW_CFG,  FUNC_INIT,  5,    0,    0, '{0, 0, 0}},
    '{ROW_ITEM, FUNC_INIT,  0,    0,    1, '{0, 0, 5}},
    '{ROW_ITEM, FUNC_ALLOC, 4,    0,    0, '{0, 0, 0}},
    '{ROW_ITEM, FUNC_ALLOC, 1,    0,    0, '{0, 0, 0}},
    '{ROW_ITEM, FUNC_ALLOC, 1,    0,    0, '{0, 0, 0}},
    '{ROW_ITEM, FUNC_NOP,   8191, 4095, 0, '{0, 0, 0}}
  };

  initial begin
    result_t none;
    int pick, roll, cnt, size_sel;
    none = '{1'b0, 12'd0, 13'd0};
    wipe_tables();
    pages_cfg = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_pages(plan[i].cnt);
      else send_item(plan[i].func, plan[i].cnt, plan[i].start, plan[i].typed, plan[i].res);
    end

    // Random phases, each opened by a new page range and an init
    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph == 4);
      case ($urandom_range(5))
        0: write_pages(4096);
        1: write_pages($urandom_range(8191, 4097));
        2: write_pages($urandom_range(64, 1));
        default: write_pages($urandom_range(4096, 0));
      endcase
      send_item(FUNC_INIT, $urandom_range(8191), $urandom_range(4095), 0, none);
      for (int k = 0; k < 100; k++) begin
        roll = $urandom_range(99);
        if (roll < 48) begin
          size_sel = $urandom_range(19);
          if (size_sel == 0) cnt = $urandom_range(8191, 1025);
          else if (size_sel == 1) cnt = 0;
          else if (size_sel < 4) cnt = $urandom_range(1024, 65);
          else cnt = $urandom_range(16, 1);
          send_item(FUNC_ALLOC, cnt, $urandom_range(4095), 0, none);
        end else if (roll < 88 && held_base.size() != 0) begin
          // Release a block handed out earlier, now and then only part of it
          pick = $urandom_range(held_base.size() - 1);
          cnt = held_size[pick];
          if ($urandom_range(9) == 0) cnt = $urandom_range(cnt, 1);
          send_item(FUNC_FREE, cnt, held_base[pick], 0, none);
          held_base.delete(pick);
          held_size.delete(pick);
        end else if (roll < 97) begin
          send_item(FUNC_FREE, $urandom_range(8191), $urandom_range(4095), 0, none);
        end else begin
          send_item(FUNC_NOP, $urandom_range(8191), $urandom_range(4095), 0, none);
        end
      end
    end
    calm = 1'b0;

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/buddy_page_allocator_top.sv
test/testbench.sv
